// ===== rtl/greedy_word_wrap_line_breaker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the line breaker modules
// Clocked implication checks, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_ASSERT_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_ASSERT_SVH

// Same-cycle implication
`define GWW_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GWW_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gww_pkg.sv =====
// ----------------------------------------------------------------------------
// gww_pkg
// Types, constants and helpers for the greedy word-wrap line breaker.
// ----------------------------------------------------------------------------
package gww_pkg;

    // Default offset width and wrap width after reset
    localparam int unsigned POS_BITS_DEF   = 16;
    localparam logic [5:0]  WRAP_WIDTH_RST = 6'd40;

    // Depth of the line descriptor queue
    localparam int unsigned FIFO_DEPTH = 4;

    // Character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_PERIOD  = 8'h2E;

    // One line descriptor
    typedef struct packed {
        logic        final_line;
        logic [15:0] line_number;
        logic [5:0]  line_length;
        logic [15:0] line_start;
    } t_line;

    // Up to two descriptors written into the queue in one cycle
    typedef struct packed {
        logic [1:0] num;
        t_line      line1;
        t_line      line0;
    } t_push;

    // Space, comma and period may end a line
    function automatic logic is_candidate(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_COMMA) || (c == CH_PERIOD);
    endfunction

endpackage

// ===== rtl/gww_res_fifo.sv =====
// ----------------------------------------------------------------------------
// gww_res_fifo
// Small queue of line descriptors: takes up to two per cycle, gives one.
// ----------------------------------------------------------------------------
module gww_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gww_pkg::t_push       i_push,
    output logic [$clog2(gww_pkg::FIFO_DEPTH):0] o_level,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gww_pkg::t_line       o_line
);
    import gww_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

    t_line              r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [PTR_W:0]     n_count;
    logic [PTR_W-1:0]   wr_ptr1;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_line  = r_mem[r_rd_ptr];
    assign o_level = r_count;
    assign wr_ptr1 = r_wr_ptr + PTR_W'(1);

    // Pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(i_push.num);
        n_rd_ptr = pop ? (r_rd_ptr + PTR_W'(1)) : r_rd_ptr;
        n_count  = r_count + (PTR_W+1)'(i_push.num) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: first entry at the write pointer, second right after it
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.line0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.line1;
        end
    end

`include "greedy_word_wrap_line_breaker_assert.svh"

    `GWW_ASSERT_IMP(a_level_bound, i_clk, i_rst_n, 1'b1, r_count <= (PTR_W+1)'(FIFO_DEPTH), "queue level beyond depth")
    `GWW_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.num != 2'd0, (r_count + (PTR_W+1)'(i_push.num)) <= (PTR_W+1)'(FIFO_DEPTH), "queue overflow")
    `GWW_ASSERT_IMP(a_push_num, i_clk, i_rst_n, 1'b1, i_push.num != 2'd3, "more than two lines pushed")

endmodule

// ===== rtl/greedy_word_wrap_line_breaker.sv =====
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker
// Greedy word wrap: one character in, line descriptors out.
// ----------------------------------------------------------------------------
// Takes one character per cycle and gives a descriptor (start offset, length,
// line number, final flag) for each line. Space, comma and period are break
// points; newline after a line's first character, or the last character, ends
// a line at once; otherwise a line closes at the latest break point within
// the wrap width, or is cut hard at the wrap width. The break test and
// offset arithmetic work on the incoming character in the accepting cycle and
// write the descriptors straight into a four-entry queue, whose head is
// visible on the cycle after the character is taken. A character is taken
// whenever the queue has room for two descriptors, so the input only stalls
// while the output side holds three or more descriptors back.
// Writing the wrap width abandons the text in progress.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker #(
    parameter int unsigned POS_BITS = gww_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: wrap width
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,
    // Characters in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_s_axis_tlast,   // is_last
    // Line descriptors out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [15:0] line_start, [21:16] line_length,
                                          // [37:22] line_number, [39:38] zero
    output logic        o_m_axis_tlast    // final_line
);
    import gww_pkg::*;

    localparam int unsigned LVL_W = $clog2(FIFO_DEPTH) + 1;

    // Text state
    logic [5:0]          r_wrap_width;
    logic [POS_BITS-1:0] r_char_pos;
    logic [POS_BITS-1:0] r_line_start;
    logic [POS_BITS-1:0] r_break_pos;
    logic                r_break_seen;
    logic [15:0]         r_line_count;

    logic [POS_BITS-1:0] n_char_pos;
    logic [POS_BITS-1:0] n_line_start;
    logic [POS_BITS-1:0] n_break_pos;
    logic                n_break_seen;
    logic [15:0]         n_line_count;

    logic                cfg_acc;
    logic                in_acc;
    logic [LVL_W-1:0]    level;
    t_push               push;
    t_line               out_line;

    // Step datapath
    logic [7:0]          ch;
    logic                last;
    logic [POS_BITS-1:0] w;
    logic [POS_BITS-1:0] p1;
    logic [POS_BITS-1:0] off;
    logic [POS_BITS-1:0] ns;
    logic [POS_BITS-1:0] len;
    logic                ended;
    logic                cand;
    t_line               first_line;
    t_line               tail_line;
    logic                have_first;

    assign ch   = i_s_axis_tdata;
    assign last = i_s_axis_tlast;

    assign o_cfg_ready     = 1'b1;
    assign cfg_acc         = i_cfg_valid;
    assign o_s_axis_tready = (level <= LVL_W'(FIFO_DEPTH - 2));
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // One character step
    always_comb begin
        w     = (r_wrap_width == 6'd0) ? POS_BITS'(1) : POS_BITS'(r_wrap_width);
        p1    = r_char_pos + POS_BITS'(1);
        off   = r_char_pos - r_line_start;
        cand  = is_candidate(ch);
        ns    = '0;
        len   = '0;
        ended = 1'b0;
        have_first   = 1'b0;
        n_line_start = r_line_start;
        n_break_pos  = r_break_pos;
        n_break_seen = r_break_seen;
        first_line   = '0;

        if (off != '0) begin
            if (ch == CH_NEWLINE) begin
                // Newline closes the line without the newline itself
                have_first   = 1'b1;
                first_line   = '{final_line: last, line_number: r_line_count,
                                 line_length: 6'(off), line_start: 16'(r_line_start)};
                n_line_start = p1;
                n_break_seen = 1'b0;
                ended        = 1'b1;
            end else begin
                if (cand) begin
                    n_break_pos  = r_char_pos;
                    n_break_seen = 1'b1;
                end
                if (off >= w) begin
                    // Word break at the latest candidate, else hard break
                    if (n_break_seen) begin
                        len = n_break_pos - r_line_start;
                        ns  = n_break_pos + POS_BITS'(1);
                    end else begin
                        len = w;
                        ns  = r_char_pos;
                    end
                    ended        = (ns == p1);
                    have_first   = 1'b1;
                    first_line   = '{final_line: last && ended, line_number: r_line_count,
                                     line_length: 6'(len), line_start: 16'(r_line_start)};
                    n_line_start = ns;
                    n_break_seen = 1'b0;
                end
            end
        end

        // Remainder line at end of text
        tail_line = '{final_line: 1'b1,
                      line_number: r_line_count + 16'(have_first),
                      line_length: 6'(p1 - n_line_start),
                      line_start: 16'(n_line_start)};

        push = '0;
        if (in_acc) begin
            if (have_first) begin
                push.line0 = first_line;
                push.line1 = tail_line;
                push.num   = (last && !ended) ? 2'd2 : 2'd1;
            end else begin
                push.line0 = tail_line;
                push.num   = (last && !ended) ? 2'd1 : 2'd0;
            end
        end

        // Next text state
        if (last) begin
            n_char_pos   = '0;
            n_line_start = '0;
            n_break_pos  = '0;
            n_break_seen = 1'b0;
            n_line_count = '0;
        end else begin
            n_char_pos   = p1;
            n_line_count = r_line_count + 16'(have_first);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width <= WRAP_WIDTH_RST;
            r_char_pos   <= '0;
            r_line_start <= '0;
            r_break_pos  <= '0;
            r_break_seen <= 1'b0;
            r_line_count <= '0;
        end else if (cfg_acc) begin
            // New width drops the text in progress
            r_wrap_width <= i_cfg_data;
            r_char_pos   <= '0;
            r_line_start <= '0;
            r_break_pos  <= '0;
            r_break_seen <= 1'b0;
            r_line_count <= '0;
        end else if (in_acc) begin
            r_char_pos   <= n_char_pos;
            r_line_start <= n_line_start;
            r_break_pos  <= n_break_pos;
            r_break_seen <= n_break_seen;
            r_line_count <= n_line_count;
        end
    end

    // Descriptor queue and output packing
    gww_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_level (level),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_line  (out_line)
    );

    assign o_m_axis_tdata = {2'b00, out_line.line_number, out_line.line_length,
                             out_line.line_start};
    assign o_m_axis_tlast = out_line.final_line;

`include "greedy_word_wrap_line_breaker_assert.svh"

    `GWW_ASSERT_IMP(a_len_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[21:16] != 6'd0, "empty line emitted")
    `GWW_ASSERT_IMP(a_off_in_width, i_clk, i_rst_n, 1'b1, (r_char_pos - r_line_start) <= POS_BITS'(63), "open line longer than width")
    `GWW_ASSERT_NXT(a_text_clear, i_clk, i_rst_n, in_acc && i_s_axis_tlast, r_char_pos == '0 && r_line_count == 16'd0, "state not cleared after last character")

endmodule

// ===== tb/sv/tb_greedy_word_wrap_line_breaker.sv =====
// ----------------------------------------------------------------------------
// Testbench for the greedy word-wrap line breaker
// Streams text characters into the block and checks every line descriptor
// against a cycle-free model of the wrap rules kept inside this bench. Covers
// newline handling, word and hard breaks, end-of-text flushes that give two
// lines, width changes that drop a text in progress, a long back-to-back text
// and random texts under random backpressure on both streams.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_line_breaker;
    timeunit 1ns;
    timeprecision 1ps;

    import gww_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned RANDOM_ITEMS  = 650;
    localparam int unsigned LONG_TEXT_LEN = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;    // [7:0] ch
    logic        i_s_axis_tlast;    // is_last
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;    // [15:0] start, [21:16] length, [37:22] number
    logic        o_m_axis_tlast;    // final_line

    greedy_word_wrap_line_breaker uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Clock: 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Wrap state mirrored from the block
    logic [5:0]  wrap_width;
    logic [15:0] text_pos;
    logic [15:0] open_line_start;
    logic [15:0] break_pos;
    logic        break_seen;
    logic [15:0] lines_emitted;

    t_line       pending_lines[$];
    int unsigned fail_cnt;
    int unsigned tx_max_gap;
    int unsigned rx_max_gap;
    int unsigned idle_cycles;

    // ------------------------------------------------------------------------
    // Line prediction
    // ------------------------------------------------------------------------
    function automatic logic breaks_here(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_COMMA, CH_PERIOD: return 1'b1;
            default:                       return 1'b0;
        endcase
    endfunction

    task automatic clear_text();
        text_pos        = '0;
        open_line_start = '0;
        break_pos       = '0;
        break_seen      = 1'b0;
        lines_emitted   = '0;
    endtask

    task automatic emit_line(input logic [15:0] start, input logic [15:0] len,
                             input logic fin);
        t_line ln;
        ln.line_start  = start;
        ln.line_length = len[5:0];
        ln.line_number = lines_emitted;
        ln.final_line  = fin;
        pending_lines.push_back(ln);
        lines_emitted = lines_emitted + 16'd1;
    endtask

    // Expected lines for one accepted character
    task automatic wrap_char(input logic [7:0] c, input logic last);
        logic [15:0] w, p, s, off, ns, len;
        logic        closed;
        w      = (wrap_width == 6'd0) ? 16'd1 : {10'd0, wrap_width};
        p      = text_pos;
        s      = open_line_start;
        off    = p - s;
        closed = 1'b0;
        // first character of a line is never a break or line end
        if (off != 16'd0) begin
            if (c == CH_NEWLINE) begin
                emit_line(s, off, last);
                s          = p + 16'd1;
                break_seen = 1'b0;
                closed     = 1'b1;
            end else begin
                if (breaks_here(c)) begin
                    break_pos  = p;
                    break_seen = 1'b1;
                end
                if (off >= w) begin
                    if (break_seen) begin
                        len = break_pos - s;
                        ns  = break_pos + 16'd1;
                    end else begin
                        len = w;
                        ns  = p;
                    end
                    closed = (ns == p + 16'd1);
                    emit_line(s, len, last && closed);
                    s          = ns;
                    break_seen = 1'b0;
                end
            end
        end
        // end of text flushes the open line and starts over
        if (last) begin
            if (!closed)
                emit_line(s, p + 16'd1 - s, 1'b1);
            clear_text();
        end else begin
            text_pos        = p + 16'd1;
            open_line_start = s;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_gap(input int unsigned max_gap);
        return (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
    endfunction

    // One character request; returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic last);
        int unsigned gap;
        gap = draw_gap(tx_max_gap);
        if (gap != 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = c;
        i_s_axis_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        wrap_char(c, last);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_lines.size() != 0)
            @(negedge i_clk);
    endtask

    // Width write only while idle; it also drops any open text
    task automatic write_wrap_width(input logic [5:0] w);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = w;
        do @(posedge i_clk); while (!o_cfg_ready);
        wrap_width = w;
        clear_text();
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly letters, with break characters, newlines and arbitrary bytes
    function automatic logic [7:0] pick_char();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60)      return 8'h61 + 8'($urandom_range(25, 0));
        else if (r < 75) return CH_SPACE;
        else if (r < 80) return CH_COMMA;
        else if (r < 85) return CH_PERIOD;
        else if (r < 90) return CH_NEWLINE;
        else             return 8'($urandom_range(255, 0));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset width; newline as a plain first char, newline ending a line,
    // all-zero and all-one bytes
    task automatic test_default_width();
        send_char(CH_NEWLINE, 1'b0);
        send_char(8'h78, 1'b0);
        send_char(CH_NEWLINE, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);
    endtask

    // Zero width acts as one; hard break plus flush gives two lines
    task automatic test_hard_break();
        write_wrap_width(6'd0);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h63, 1'b1);
    endtask

    // Word breaks with space, comma and period, break char dropped at the end
    task automatic test_word_break();
        write_wrap_width(6'd3);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(8'h63, 1'b1);
        send_char(8'h61, 1'b0);
        send_char(8'h62, 1'b0);
        send_char(8'h63, 1'b0);
        send_char(CH_SPACE, 1'b1);
        write_wrap_width(6'd2);
        send_char(8'h78, 1'b0);
        send_char(CH_COMMA, 1'b0);
        send_char(8'h79, 1'b0);
        send_char(CH_PERIOD, 1'b0);
        send_char(8'h7A, 1'b1);
    endtask

    // Width write in the middle of a text drops it
    task automatic test_abandon_on_write();
        write_wrap_width(6'd63);
        send_char(8'h71, 1'b0);
        send_char(8'h72, 1'b0);
        write_wrap_width(6'd40);
        send_char(8'h73, 1'b1);
    endtask

    // One long text at the narrowest width, streamed back to back
    task automatic test_long_text();
        int unsigned k;
        write_wrap_width(6'd1);
        tx_max_gap = 0;
        rx_max_gap = 0;
        for (k = 0; k < LONG_TEXT_LEN; k++)
            send_char(pick_char(), k == LONG_TEXT_LEN - 1);
    endtask

    // Random texts over many widths and idle patterns
    task automatic test_random_texts();
        int unsigned n_items, phase, text_len, k, t;
        logic [5:0]  w;
        n_items = 0;
        phase   = 0;
        while (n_items < RANDOM_ITEMS) begin
            case (phase % 6)
                0:       w = 6'd1;
                1:       w = 6'd63;
                2:       w = 6'($urandom_range(63, 13));
                default: w = 6'($urandom_range(12, 1));
            endcase
            write_wrap_width(w);
            case (phase % 4)
                0: begin tx_max_gap = 0;  rx_max_gap = 0;  end
                1: begin tx_max_gap = 17; rx_max_gap = 0;  end
                2: begin tx_max_gap = 0;  rx_max_gap = 17; end
                default: begin tx_max_gap = 17; rx_max_gap = 17; end
            endcase
            for (t = 0; t < 4; t++) begin
                text_len = $urandom_range(2 * w + 6, 1);
                for (k = 0; k < text_len; k++) begin
                    // sender holds off once until all lines are out
                    if (phase == 3 && t == 1 && k == text_len / 2)
                        wait_drained();
                    send_char(pick_char(), k == text_len - 1);
                    n_items++;
                end
            end
            // sometimes leave a text open for the next width write to drop
            if ($urandom_range(1, 0)) begin
                text_len = $urandom_range(5, 1);
                for (k = 0; k < text_len; k++) begin
                    send_char(pick_char(), 1'b0);
                    n_items++;
                end
            end
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall before each descriptor
    // ------------------------------------------------------------------------
    initial begin : line_sink
        int unsigned gap;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = draw_gap(rx_max_gap);
            if (gap != 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Descriptor check against the oldest expected line
    // ------------------------------------------------------------------------
    task automatic report_field(input string field, input longint unsigned want,
                                input longint unsigned got);
        fail_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field,
                 want, got);
    endtask

    always @(posedge i_clk) begin : check_lines
        t_line want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_lines.size() == 0) begin
                report_field("unexpected line, tdata", 0, o_m_axis_tdata);
            end else begin
                want = pending_lines.pop_front();
                if (o_m_axis_tdata[15:0] != want.line_start)
                    report_field("line_start", want.line_start, o_m_axis_tdata[15:0]);
                if (o_m_axis_tdata[21:16] != want.line_length)
                    report_field("line_length", want.line_length, o_m_axis_tdata[21:16]);
                if (o_m_axis_tdata[37:22] != want.line_number)
                    report_field("line_number", want.line_number, o_m_axis_tdata[37:22]);
                if (o_m_axis_tlast != want.final_line)
                    report_field("final_line", want.final_line, o_m_axis_tlast);
                if (o_m_axis_tdata[39:38] != 2'b00)
                    report_field("tdata padding", 0, o_m_axis_tdata[39:38]);
            end
        end
    end

    // Watchdog: too long without any request moving
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        fail_cnt        = 0;
        idle_cycles     = 0;
        tx_max_gap      = 17;
        rx_max_gap      = 17;
        wrap_width      = WRAP_WIDTH_RST;
        clear_text();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_width();
        test_hard_break();
        test_word_break();
        test_abandon_on_write();
        test_long_text();
        test_random_texts();

        wait_drained();
        repeat (SETTLE_CYCLES * 2) @(negedge i_clk);
        if (fail_cnt == 0 && pending_lines.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
